### rtl/ckt_pkg.sv
// ----------------------------------------------------------------------------
// Chunk key table package
// Shared types and codes for the chunk key table: request modes, result
// status codes, the stored key format and the controller states.
// ----------------------------------------------------------------------------
package ckt_pkg;

  localparam int KEY_W   = 28;
  localparam int COORD_W = 32;
  localparam int LOCAL_W = 4;
  localparam int SLOT_W  = 10;

  localparam logic [2:0] MODE_INSERT        = 3'd0;
  localparam logic [2:0] MODE_DELETE        = 3'd1;
  localparam logic [2:0] MODE_LOOKUP        = 3'd2;
  localparam logic [2:0] MODE_LOCATE        = 3'd3;
  localparam logic [2:0] MODE_LOCATE_CREATE = 3'd4;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_EXISTS    = 3'd1;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd2;
  localparam logic [2:0] STATUS_FULL      = 3'd3;
  localparam logic [2:0] STATUS_RANGE     = 3'd4;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [LOCAL_W-1:0] local_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] z;
    logic signed [KEY_W-1:0] y;
    logic signed [KEY_W-1:0] x;
  } key_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       reject;
    logic [2:0] reject_status;
    key_t       key;
    local_t     lx;
    local_t     ly;
    local_t     lz;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    slot_t      slot;
    key_t       key;
    local_t     lx;
    local_t     ly;
    local_t     lz;
    logic       moved;
    slot_t      moved_from;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR,
    S_FINISH
  } state_t;

endpackage

### rtl/ckt_key_ram.sv
// ----------------------------------------------------------------------------
// Chunk key table key memory
// Single-port-write, single-port-read synchronous memory holding the packed
// keys, with a registered read port.
// ----------------------------------------------------------------------------
module ckt_key_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  ckt_pkg::key_t     wdata,
  input  logic [ADDR_W-1:0] raddr,
  output ckt_pkg::key_t     rdata
);

  ckt_pkg::key_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ckt_req_decode.sv
// ----------------------------------------------------------------------------
// Chunk key table request decoder
// Turns a request into a chunk key: a range-checked chunk coordinate in the
// table modes, or a floor division by 16 with local offsets in the locate
// modes. Flags requests that finish without touching the table.
// ----------------------------------------------------------------------------
module ckt_req_decode (
  input  logic [2:0]                    mode,
  input  logic [ckt_pkg::COORD_W-1:0]   coord_x,
  input  logic [ckt_pkg::COORD_W-1:0]   coord_y,
  input  logic [ckt_pkg::COORD_W-1:0]   coord_z,
  output ckt_pkg::req_t                 req
);

  logic fit_x;
  logic fit_y;
  logic fit_z;

  assign fit_x = (coord_x[31:27] == {5{coord_x[27]}});
  assign fit_y = (coord_y[31:27] == {5{coord_y[27]}});
  assign fit_z = (coord_z[31:27] == {5{coord_z[27]}});

  always_comb begin
    req      = '0;
    req.mode = mode;
    case (mode) inside
      ckt_pkg::MODE_INSERT, ckt_pkg::MODE_DELETE, ckt_pkg::MODE_LOOKUP: begin
        if (fit_x && fit_y && fit_z) begin
          req.key.x = coord_x[27:0];
          req.key.y = coord_y[27:0];
          req.key.z = coord_z[27:0];
        end else begin
          req.reject        = 1'b1;
          req.reject_status = ckt_pkg::STATUS_RANGE;
        end
      end
      ckt_pkg::MODE_LOCATE, ckt_pkg::MODE_LOCATE_CREATE: begin
        req.key.x = coord_x[31:4];
        req.key.y = coord_y[31:4];
        req.key.z = coord_z[31:4];
        req.lx    = coord_x[3:0];
        req.ly    = coord_y[3:0];
        req.lz    = coord_z[3:0];
      end
      default: begin
        req.reject        = 1'b1;
        req.reject_status = ckt_pkg::STATUS_NOT_FOUND;
      end
    endcase
  end

endmodule

### rtl/chunk_key_table.sv
// ----------------------------------------------------------------------------
// Chunk key table
// Packed table of 3D chunk keys with insert, swap-with-last delete, lookup,
// locate and locate-or-create requests, one result per request.
// ----------------------------------------------------------------------------
// One request at a time. A request scans the key memory one entry per cycle,
// stopping at the first matching slot or after the last entry on a miss. A
// delete that moves the last entry also passes through S_MOVE_RD and S_MOVE_WR,
// and a rejected request goes straight to S_FINISH without a scan.
// The next request can transfer in the cycle after a result is loaded, even while
// it waits for the receiver. Reset empties the table; the memory is not cleared.
module chunk_key_table #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // coord_x [31:0], coord_y [63:32], coord_z [95:64]
  input  logic [95:0]  s_axis_tdata,
  // mode [2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // slot [9:0], chunk_x [37:10], chunk_y [65:38], chunk_z [93:66],
  // local_x [97:94], local_y [101:98], local_z [105:102], moved [106],
  // moved_from [116:107], zero [119:117]
  output logic [119:0] m_axis_tdata,
  // status [2:0]
  output logic [2:0]   m_axis_tuser
);

  localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);

  ckt_pkg::state_t  state;
  ckt_pkg::state_t  state_next;
  ckt_pkg::req_t    req;
  ckt_pkg::req_t    req_dec;
  ckt_pkg::result_t res;
  ckt_pkg::result_t res_next;

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] scan_idx;
  logic [COUNT_W-1:0] scan_idx_next;
  logic [COUNT_W-1:0] last;
  logic [ADDR_W-1:0]  cmp_idx;
  logic [ADDR_W-1:0]  cmp_idx_next;
  logic [ADDR_W-1:0]  hit_idx;
  logic [ADDR_W-1:0]  hit_idx_next;
  logic               cmp_valid;
  logic               cmp_valid_next;
  logic               hit;
  logic               hit_next;
  logic               out_valid;
  logic               out_load;
  logic               out_free;
  logic               in_xfer;
  logic               full;
  logic               issue;
  logic               match;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  ckt_pkg::key_t      ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  ckt_pkg::key_t      ram_rdata;

  ckt_req_decode u_decode (
    .mode    (s_axis_tuser),
    .coord_x (s_axis_tdata[31:0]),
    .coord_y (s_axis_tdata[63:32]),
    .coord_z (s_axis_tdata[95:64]),
    .req     (req_dec)
  );

  ckt_key_ram #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_axis_tready = (state == ckt_pkg::S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign last          = count - 1'b1;
  assign full          = (count == COUNT_W'(TABLE_DEPTH));
  assign issue         = (scan_idx < count);
  assign match         = cmp_valid && (ram_rdata == req.key);

  always_comb begin
    state_next     = state;
    count_next     = count;
    scan_idx_next  = scan_idx;
    cmp_idx_next   = scan_idx[ADDR_W-1:0];
    cmp_valid_next = 1'b0;
    hit_next       = hit;
    hit_idx_next   = hit_idx;
    ram_we         = 1'b0;
    ram_waddr      = count[ADDR_W-1:0];
    ram_wdata      = req.key;
    ram_raddr      = scan_idx[ADDR_W-1:0];
    out_load       = 1'b0;

    res_next            = '0;
    res_next.status     = ckt_pkg::STATUS_OK;
    res_next.key        = req.key;
    res_next.lx         = req.lx;
    res_next.ly         = req.ly;
    res_next.lz         = req.lz;

    case (state)
      ckt_pkg::S_IDLE: begin
        if (in_xfer) begin
          scan_idx_next = '0;
          hit_next      = 1'b0;
          state_next    = req_dec.reject ? ckt_pkg::S_FINISH : ckt_pkg::S_SCAN;
        end
      end
      ckt_pkg::S_SCAN: begin
        if (match) begin
          hit_next     = 1'b1;
          hit_idx_next = cmp_idx;
          if (req.mode == ckt_pkg::MODE_DELETE && cmp_idx != last[ADDR_W-1:0]) begin
            state_next = ckt_pkg::S_MOVE_RD;
          end else begin
            state_next = ckt_pkg::S_FINISH;
          end
        end else if (!issue) begin
          hit_next   = 1'b0;
          state_next = ckt_pkg::S_FINISH;
        end else begin
          scan_idx_next  = scan_idx + 1'b1;
          cmp_valid_next = 1'b1;
        end
      end
      ckt_pkg::S_MOVE_RD: begin
        ram_raddr  = last[ADDR_W-1:0];
        state_next = ckt_pkg::S_MOVE_WR;
      end
      ckt_pkg::S_MOVE_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = hit_idx;
        ram_wdata  = ram_rdata;
        state_next = ckt_pkg::S_FINISH;
      end
      ckt_pkg::S_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ckt_pkg::S_IDLE;
          if (req.reject) begin
            res_next.status = req.reject_status;
          end else begin
            case (req.mode)
              ckt_pkg::MODE_INSERT, ckt_pkg::MODE_LOCATE_CREATE: begin
                if (hit) begin
                  res_next.slot   = ckt_pkg::slot_t'(hit_idx);
                  res_next.status = (req.mode == ckt_pkg::MODE_INSERT) ?
                                    ckt_pkg::STATUS_EXISTS : ckt_pkg::STATUS_OK;
                end else if (full) begin
                  res_next.status = ckt_pkg::STATUS_FULL;
                end else begin
                  ram_we        = 1'b1;
                  res_next.slot = ckt_pkg::slot_t'(count);
                  count_next    = count + 1'b1;
                end
              end
              ckt_pkg::MODE_DELETE: begin
                if (hit) begin
                  res_next.slot = ckt_pkg::slot_t'(hit_idx);
                  count_next    = last;
                  if (hit_idx != last[ADDR_W-1:0]) begin
                    res_next.moved      = 1'b1;
                    res_next.moved_from = ckt_pkg::slot_t'(last);
                  end
                end else begin
                  res_next.status = ckt_pkg::STATUS_NOT_FOUND;
                end
              end
              ckt_pkg::MODE_LOOKUP, ckt_pkg::MODE_LOCATE: begin
                if (hit) begin
                  res_next.slot = ckt_pkg::slot_t'(hit_idx);
                end else begin
                  res_next.status = ckt_pkg::STATUS_NOT_FOUND;
                end
              end
              default: begin
                res_next.status = ckt_pkg::STATUS_NOT_FOUND;
              end
            endcase
          end
        end
      end
      default: begin
        state_next = ckt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ckt_pkg::S_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cmp_valid <= cmp_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    cmp_idx  <= cmp_idx_next;
    hit      <= hit_next;
    hit_idx  <= hit_idx_next;
    if (in_xfer) begin
      req <= req_dec;
    end
    if (out_load) begin
      res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = res.status;
  assign m_axis_tdata  = {3'b000, res.moved_from, res.moved, res.lz, res.ly, res.lx,
                          res.key.z, res.key.y, res.key.x, res.slot};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_cmp_in_table: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (COUNT_W'(cmp_idx) < count))
    else $error("compare of a slot beyond the entry count");

  a_move_shrinks: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_next.moved) |=> (count == $past(count) - 1'b1))
    else $error("delete with move did not shrink the table");

  a_scan_only_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ckt_pkg::S_SCAN) |-> !s_axis_tready)
    else $error("input taken during a table scan");

endmodule
